// ===== hw/rtl/per_channel_latency_rate_monitor_top_macros.svh =====
// Assertion macros for the latency and rate monitor RTL, used by pclrm_dp.
// Depends on nothing; users provide clk and rst_n in scope.
`ifndef PER_CHANNEL_LATENCY_RATE_MONITOR_TOP_MACROS_SVH
`define PER_CHANNEL_LATENCY_RATE_MONITOR_TOP_MACROS_SVH

// same-cycle implication
`define PCLRM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PCLRM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/pclrm_pkg.sv =====
// Package for the latency and rate monitor: constants, command codes, structs.
// Used by the datapath, controller and top; depends on nothing.
package pclrm_pkg;

  localparam int NUM_CH = 6;
  localparam logic [2:0] CH_MAX = 3'(NUM_CH - 1);
  localparam logic [31:0] FALLBACK_HZ = 32'd216000000;
  localparam logic [19:0] US_PER_S = 20'd1000000;
  localparam logic [9:0] MS_PER_S = 10'd1000;

  // event kinds
  localparam logic [1:0] FN_IRQ = 2'd0;
  localparam logic [1:0] FN_READ = 2'd1;
  localparam logic [1:0] FN_SNAP = 2'd2;

  // register indexes
  localparam logic [1:0] REG_PERIOD = 2'd0;
  localparam logic [1:0] REG_HZ = 2'd1;
  localparam logic [1:0] REG_USABLE = 2'd2;

  // span selects
  localparam logic [1:0] SEL_IRQ_READ = 2'd0;
  localparam logic [1:0] SEL_READ = 2'd1;
  localparam logic [1:0] SEL_SNAP = 2'd2;

  // datapath operations
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_LATCH = 4'd1;
  localparam logic [3:0] OP_IRQ = 4'd2;
  localparam logic [3:0] OP_READ_PRE = 4'd3;
  localparam logic [3:0] OP_SNAP_PRE = 4'd4;
  localparam logic [3:0] OP_DIFF = 4'd5;
  localparam logic [3:0] OP_MUL = 4'd6;
  localparam logic [3:0] OP_DIV_SPAN = 4'd7;
  localparam logic [3:0] OP_ACC = 4'd8;
  localparam logic [3:0] OP_REP_START = 4'd9;
  localparam logic [3:0] OP_FPS_MUL = 4'd10;
  localparam logic [3:0] OP_DIV_FPS = 4'd11;
  localparam logic [3:0] OP_TAKE_FPS = 4'd12;
  localparam logic [3:0] OP_DIV_MEAN = 4'd13;
  localparam logic [3:0] OP_TAKE_MEAN = 4'd14;
  localparam logic [3:0] OP_LINE = 4'd15;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] sel;
    logic [2:0] ch;
    logic [1:0] k;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic idx_ok;
    logic [2:0] idx;
    logic [NUM_CH-1:0] stamp_nz;
    logic [5:0] flags;
    logic [5:0] mask;
    logic usable;
    logic due;
    logic div_busy;
    logic out_full;
  } stat_t;

  typedef struct packed {
    logic [15:0] period;
    logic [31:0] hz;
    logic usable;
  } cfg_t;

  typedef struct packed {
    logic last;
    logic [31:0] dropped;
    logic [31:0] snap_us;
    logic [31:0] read_us;
    logic [31:0] irq_read_us;
    logic [31:0] fps;
    logic [2:0] sensor;
  } line_t;

endpackage

// ===== hw/rtl/pclrm_div.sv =====
// Restoring divider, one quotient bit per cycle, 32 or 64 steps.
// Depends on nothing but its ports.
module pclrm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        half,      // dividend fits 32 bits
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quot
);

  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] q_r, q_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dv_r, dv_nxt;
  logic [32:0] rem_s;
  logic        ge;

  assign rem_s = {rem_r, q_r[63]};
  assign ge = rem_s >= {1'b0, dv_r};

  // one shift-subtract step per cycle
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    dv_nxt = dv_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = half ? 6'd31 : 6'd63;
      q_nxt = half ? {dividend[31:0], 32'd0} : dividend;
      rem_nxt = 32'd0;
      dv_nxt = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? 32'(rem_s - {1'b0, dv_r}) : rem_s[31:0];
      q_nxt = {q_r[62:0], ge};
      if (cnt_r == 6'd0) busy_nxt = 1'b0;
      else cnt_nxt = cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    dv_r <= dv_nxt;
  end

  assign busy = busy_r;
  assign quot = q_r[31:0];

endmodule

// ===== hw/rtl/pclrm_dp.sv =====
// Datapath: item latch, per-channel counters and sums, report line register.
// Depends on pclrm_pkg and pclrm_div.
`include "per_channel_latency_rate_monitor_top_macros.svh"
module pclrm_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  pclrm_pkg::cmd_t     cmd,
  input  pclrm_pkg::cfg_t     cfg,
  input  logic [119:0]        in_item,
  input  logic                out_take,
  output pclrm_pkg::stat_t    stat,
  output pclrm_pkg::line_t    line,
  output logic                out_valid
);

  localparam int N = pclrm_pkg::NUM_CH;

  // latched item
  logic [1:0]  func_r;
  logic [7:0]  idx_r;
  logic [31:0] t0_r, t1_r, now_r;
  logic        ok_r;
  logic [5:0]  flags_r, present_r;

  // channel state
  logic [31:0] stamp_r [N];
  logic [31:0] irq_tot_r [N];
  logic [31:0] good_r [N];
  logic [31:0] sum_r [3][N];
  logic [31:0] cnt_r [3][N];
  logic [31:0] pri_irq_r [N];
  logic [31:0] pri_good_r [N];
  logic [5:0]  seen_r;
  logic [31:0] last_r;
  logic        tbs_r;

  // work registers
  logic [31:0] d_r, elapsed_r, fps_r;
  logic [63:0] prod_r;
  logic [5:0]  mask_r;
  logic [31:0] mean_r [3];
  pclrm_pkg::line_t line_r;
  logic        out_valid_r;

  logic [2:0]  ix, ch, tgt;
  logic [31:0] hz_eff, elapsed, rd_delta, id_delta, acc_v, span_from, span_to;
  logic        div_start, div_half, div_busy;
  logic [63:0] div_dend;
  logic [31:0] div_sor, quot;
  logic [5:0]  above;
  logic        line_op;

  assign ix = idx_r[2:0];
  assign ch = cmd.ch;
  assign hz_eff = (cfg.hz != 32'd0) ? cfg.hz : pclrm_pkg::FALLBACK_HZ;
  assign elapsed = now_r - last_r;
  assign rd_delta = good_r[ch] - pri_good_r[ch];
  assign id_delta = irq_tot_r[ch] - pri_irq_r[ch];
  assign tgt = (cmd.sel == pclrm_pkg::SEL_SNAP) ? ch : ix;
  assign acc_v = cfg.usable ? quot : d_r;
  assign above = mask_r >> (ch + 3'd1);
  assign line_op = cmd.op == pclrm_pkg::OP_LINE;

  // span endpoints
  always_comb begin
    span_from = t0_r;
    span_to = t1_r;
    case (cmd.sel)
      pclrm_pkg::SEL_IRQ_READ: begin
        span_from = stamp_r[ix];
        span_to = t0_r;
      end
      pclrm_pkg::SEL_SNAP: begin
        span_from = stamp_r[ch];
        span_to = t0_r;
      end
      default: begin
        span_from = t0_r;
        span_to = t1_r;
      end
    endcase
  end

  // divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_half = 1'b1;
    div_dend = prod_r;
    div_sor = elapsed_r;
    case (cmd.op)
      pclrm_pkg::OP_DIV_SPAN: begin
        div_start = 1'b1;
        div_half = 1'b0;
        div_sor = hz_eff;
      end
      pclrm_pkg::OP_DIV_FPS: begin
        div_start = 1'b1;
      end
      pclrm_pkg::OP_DIV_MEAN: begin
        div_start = 1'b1;
        div_dend = {32'd0, sum_r[cmd.k][ch]};
        div_sor = cnt_r[cmd.k][ch];
      end
      default: div_start = 1'b0;
    endcase
  end

  pclrm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .half(div_half),
    .dividend(div_dend), .divisor(div_sor), .busy(div_busy), .quot(quot)
  );

  // item latch and work registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      pclrm_pkg::OP_LATCH: begin
        func_r <= in_item[1:0];
        idx_r <= in_item[9:2];
        t0_r <= in_item[41:10];
        t1_r <= in_item[73:42];
        ok_r <= in_item[74];
        flags_r <= in_item[80:75];
        present_r <= in_item[86:81];
        now_r <= in_item[118:87];
      end
      pclrm_pkg::OP_DIFF: d_r <= span_to - span_from;
      // full 64-bit product of ticks and microseconds per second
      pclrm_pkg::OP_MUL: prod_r <= {32'd0, d_r} * {44'd0, pclrm_pkg::US_PER_S};
      pclrm_pkg::OP_REP_START: begin
        elapsed_r <= (elapsed == 32'd0) ? 32'd1 : elapsed;
        mask_r <= (func_r == pclrm_pkg::FN_SNAP && present_r != 6'd0) ? present_r : seen_r;
      end
      pclrm_pkg::OP_FPS_MUL:
        prod_r <= {32'd0, 32'(rd_delta * pclrm_pkg::MS_PER_S) + (elapsed_r >> 1)};
      pclrm_pkg::OP_TAKE_FPS: fps_r <= quot;
      pclrm_pkg::OP_TAKE_MEAN:
        mean_r[cmd.k] <= (cnt_r[cmd.k][ch] == 32'd0) ? 32'd0 : quot;
      pclrm_pkg::OP_LINE: begin
        line_r.sensor <= ch;
        line_r.fps <= fps_r;
        line_r.irq_read_us <= mean_r[0];
        line_r.read_us <= mean_r[1];
        line_r.snap_us <= mean_r[2];
        line_r.dropped <= (id_delta > rd_delta) ? id_delta - rd_delta : 32'd0;
        line_r.last <= (ch == pclrm_pkg::CH_MAX) || (above == 6'd0);
      end
      default: d_r <= d_r;
    endcase
  end

  // channel state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        stamp_r[i] <= 32'd0;
        irq_tot_r[i] <= 32'd0;
        good_r[i] <= 32'd0;
        pri_irq_r[i] <= 32'd0;
        pri_good_r[i] <= 32'd0;
        for (int j = 0; j < 3; j++) begin
          sum_r[j][i] <= 32'd0;
          cnt_r[j][i] <= 32'd0;
        end
      end
      seen_r <= 6'd0;
      last_r <= 32'd0;
      tbs_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_take) out_valid_r <= 1'b0;
      // time base on the first stamped item
      if ((cmd.op == pclrm_pkg::OP_IRQ || cmd.op == pclrm_pkg::OP_READ_PRE ||
           cmd.op == pclrm_pkg::OP_SNAP_PRE) && !tbs_r) begin
        last_r <= now_r;
        tbs_r <= 1'b1;
      end
      case (cmd.op)
        pclrm_pkg::OP_IRQ: begin
          stamp_r[ix] <= t0_r;
          irq_tot_r[ix] <= irq_tot_r[ix] + 32'd1;
          seen_r <= seen_r | (6'd1 << ix);
        end
        pclrm_pkg::OP_READ_PRE: begin
          seen_r <= seen_r | (6'd1 << ix);
          if (ok_r) good_r[ix] <= good_r[ix] + 32'd1;
        end
        pclrm_pkg::OP_SNAP_PRE: seen_r <= seen_r | present_r;
        pclrm_pkg::OP_ACC: begin
          sum_r[cmd.sel][tgt] <= sum_r[cmd.sel][tgt] + acc_v;
          cnt_r[cmd.sel][tgt] <= cnt_r[cmd.sel][tgt] + 32'd1;
        end
        pclrm_pkg::OP_REP_START: last_r <= now_r;
        pclrm_pkg::OP_TAKE_MEAN: begin
          sum_r[cmd.k][ch] <= 32'd0;
          cnt_r[cmd.k][ch] <= 32'd0;
        end
        pclrm_pkg::OP_LINE: begin
          pri_irq_r[ch] <= irq_tot_r[ch];
          pri_good_r[ch] <= good_r[ch];
          out_valid_r <= 1'b1;
        end
        default: seen_r <= seen_r;
      endcase
    end
  end

  // status to the controller
  always_comb begin
    stat.func = func_r;
    stat.idx_ok = idx_r < 8'(N);
    stat.idx = ix;
    for (int i = 0; i < N; i++) stat.stamp_nz[i] = stamp_r[i] != 32'd0;
    stat.flags = flags_r;
    stat.mask = mask_r;
    stat.usable = cfg.usable;
    stat.due = elapsed >= {16'd0, cfg.period};
    stat.div_busy = div_busy;
    stat.out_full = out_valid_r;
  end

  assign line = line_r;
  assign out_valid = out_valid_r;

  `PCLRM_ASSERT_IMP(a_div_idle, div_start, !div_busy, "divider started while busy")
  `PCLRM_ASSERT_IMP(a_line_free, line_op, !out_valid_r || out_take, "line overwrites pending line")
  `PCLRM_ASSERT_NXT(a_tbs_sticky, tbs_r, tbs_r, "time base flag cleared")

endmodule

// ===== hw/rtl/pclrm_ctrl.sv =====
// Controller: sequences one item through spans, accumulation and report lines.
// Depends on pclrm_pkg; drives the datapath by command.
module pclrm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pclrm_pkg::stat_t stat,
  output pclrm_pkg::cmd_t  cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DISP = 5'd1;
  localparam logic [4:0] S_RD_IRQ = 5'd2;
  localparam logic [4:0] S_RD_TIME = 5'd3;
  localparam logic [4:0] S_SP_MUL = 5'd4;
  localparam logic [4:0] S_SP_DIV = 5'd5;
  localparam logic [4:0] S_SP_WAIT = 5'd6;
  localparam logic [4:0] S_SP_ACC = 5'd7;
  localparam logic [4:0] S_SN_CHK = 5'd8;
  localparam logic [4:0] S_SN_NEXT = 5'd9;
  localparam logic [4:0] S_REP = 5'd10;
  localparam logic [4:0] S_LN_CHK = 5'd11;
  localparam logic [4:0] S_FPS_DIV = 5'd12;
  localparam logic [4:0] S_FPS_WAIT = 5'd13;
  localparam logic [4:0] S_M_DIV = 5'd14;
  localparam logic [4:0] S_M_WAIT = 5'd15;
  localparam logic [4:0] S_LINE = 5'd16;

  logic [4:0] state_r, state_nxt, ret_r, ret_nxt;
  logic [1:0] sel_r, sel_nxt, k_r, k_nxt;
  logic [2:0] ch_r, ch_nxt;

  assign in_ready = state_r == S_IDLE;

  // next state and command
  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    sel_nxt = sel_r;
    k_nxt = k_r;
    ch_nxt = ch_r;
    cmd.op = pclrm_pkg::OP_NONE;
    cmd.sel = sel_r;
    cmd.ch = ch_r;
    cmd.k = k_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = pclrm_pkg::OP_LATCH;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_IDLE;
        case (stat.func)
          pclrm_pkg::FN_IRQ: if (stat.idx_ok) cmd.op = pclrm_pkg::OP_IRQ;
          pclrm_pkg::FN_READ: begin
            if (stat.idx_ok) begin
              cmd.op = pclrm_pkg::OP_READ_PRE;
              state_nxt = S_RD_IRQ;
            end
          end
          pclrm_pkg::FN_SNAP: begin
            cmd.op = pclrm_pkg::OP_SNAP_PRE;
            ch_nxt = 3'd0;
            state_nxt = S_SN_CHK;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_RD_IRQ: begin
        if (stat.stamp_nz[stat.idx]) begin
          cmd.op = pclrm_pkg::OP_DIFF;
          cmd.sel = pclrm_pkg::SEL_IRQ_READ;
          sel_nxt = pclrm_pkg::SEL_IRQ_READ;
          ret_nxt = S_RD_TIME;
          state_nxt = S_SP_MUL;
        end else begin
          state_nxt = S_RD_TIME;
        end
      end
      S_RD_TIME: begin
        cmd.op = pclrm_pkg::OP_DIFF;
        cmd.sel = pclrm_pkg::SEL_READ;
        sel_nxt = pclrm_pkg::SEL_READ;
        ret_nxt = S_REP;
        state_nxt = S_SP_MUL;
      end
      S_SP_MUL: begin
        if (stat.usable) begin
          cmd.op = pclrm_pkg::OP_MUL;
          state_nxt = S_SP_DIV;
        end else begin
          state_nxt = S_SP_ACC;
        end
      end
      S_SP_DIV: begin
        cmd.op = pclrm_pkg::OP_DIV_SPAN;
        state_nxt = S_SP_WAIT;
      end
      S_SP_WAIT: if (!stat.div_busy) state_nxt = S_SP_ACC;
      S_SP_ACC: begin
        cmd.op = pclrm_pkg::OP_ACC;
        state_nxt = ret_r;
      end
      S_SN_CHK: begin
        if (stat.flags[ch_r] && stat.stamp_nz[ch_r]) begin
          cmd.op = pclrm_pkg::OP_DIFF;
          cmd.sel = pclrm_pkg::SEL_SNAP;
          sel_nxt = pclrm_pkg::SEL_SNAP;
          ret_nxt = S_SN_NEXT;
          state_nxt = S_SP_MUL;
        end else begin
          state_nxt = S_SN_NEXT;
        end
      end
      S_SN_NEXT: begin
        if (ch_r == pclrm_pkg::CH_MAX) begin
          state_nxt = S_REP;
        end else begin
          ch_nxt = ch_r + 3'd1;
          state_nxt = S_SN_CHK;
        end
      end
      S_REP: begin
        state_nxt = S_IDLE;
        if (stat.due) begin
          cmd.op = pclrm_pkg::OP_REP_START;
          ch_nxt = 3'd0;
          state_nxt = S_LN_CHK;
        end
      end
      S_LN_CHK: begin
        if (stat.mask[ch_r]) begin
          cmd.op = pclrm_pkg::OP_FPS_MUL;
          state_nxt = S_FPS_DIV;
        end else if (ch_r == pclrm_pkg::CH_MAX) begin
          state_nxt = S_IDLE;
        end else begin
          ch_nxt = ch_r + 3'd1;
        end
      end
      S_FPS_DIV: begin
        cmd.op = pclrm_pkg::OP_DIV_FPS;
        state_nxt = S_FPS_WAIT;
      end
      S_FPS_WAIT: begin
        if (!stat.div_busy) begin
          cmd.op = pclrm_pkg::OP_TAKE_FPS;
          k_nxt = 2'd0;
          state_nxt = S_M_DIV;
        end
      end
      S_M_DIV: begin
        cmd.op = pclrm_pkg::OP_DIV_MEAN;
        state_nxt = S_M_WAIT;
      end
      S_M_WAIT: begin
        if (!stat.div_busy) begin
          cmd.op = pclrm_pkg::OP_TAKE_MEAN;
          if (k_r == 2'd2) begin
            state_nxt = S_LINE;
          end else begin
            k_nxt = k_r + 2'd1;
            state_nxt = S_M_DIV;
          end
        end
      end
      S_LINE: begin
        if (!stat.out_full) begin
          cmd.op = pclrm_pkg::OP_LINE;
          if (ch_r == pclrm_pkg::CH_MAX || (stat.mask >> (ch_r + 3'd1)) == 6'd0) begin
            state_nxt = S_IDLE;
          end else begin
            ch_nxt = ch_r + 3'd1;
            state_nxt = S_LN_CHK;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    ret_r <= ret_nxt;
    sel_r <= sel_nxt;
    k_r <= k_nxt;
    ch_r <= ch_nxt;
  end

endmodule

// ===== hw/rtl/per_channel_latency_rate_monitor_top.sv =====
// Per-channel latency and rate monitor, top level with configuration registers.
// Depends on pclrm_pkg, pclrm_ctrl, pclrm_dp.
//
// Usage: events enter on the in_ stream, one item per handshake; report lines
// leave on the out_ stream, out_tlast marking the final line of a report.
// Registers on the cfg_ port: 0x0 report period (ms), 0x4 counter rate (Hz),
// 0x8 cycle counter usable; write only while no item is in flight.
// Per item, handshake to next ready: an interrupt mark is latched and then
// recorded; a read records the read, then the irq-to-read span when a stamp
// is held and then the read span; each span runs in the 64-step divider when
// ticks are cycles. A snapshot checks each channel in turn and measures the
// span of each sampled channel. A due report steps over unlisted channels and
// runs four 32-step divisions per line in the shared divider; the longest item
// is a fully sampled snapshot with six lines.
// The controller handles one item at a time; in_tready is high only when idle.
// Reset clears all counters, sums and stamps at once; no clearing pass.
// A stalled receiver holds the pending line in the output register; the next
// line waits behind it, and a new item is still taken once the report ends.
module per_channel_latency_rate_monitor_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // func, channel, start ticks, stop ticks, read_ok, snapshot_flags,
  // presence bits, now_ms (from bit 0 up), zero padded
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // sensor, frames_per_second, irq_to_read_us, read_us, irq_to_snapshot_us,
  // dropped (from bit 0 up), zero padded
  output logic [167:0] out_tdata,
  output logic         out_tlast,  // last_of_report
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [15:0] period_r;
  logic [31:0] hz_r;
  logic        usable_r;
  logic        wr;
  pclrm_pkg::cfg_t  cfg;
  pclrm_pkg::cmd_t  cmd;
  pclrm_pkg::stat_t stat;
  pclrm_pkg::line_t line;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= 16'd1000;
      hz_r <= 32'd216000000;
      usable_r <= 1'b1;
    end else if (wr) begin
      case (cfg_paddr[3:2])
        pclrm_pkg::REG_PERIOD: period_r <= cfg_pwdata[15:0];
        pclrm_pkg::REG_HZ: hz_r <= cfg_pwdata;
        pclrm_pkg::REG_USABLE: usable_r <= cfg_pwdata[0];
        default: period_r <= period_r;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_paddr[3:2])
      pclrm_pkg::REG_PERIOD: cfg_prdata = {16'd0, period_r};
      pclrm_pkg::REG_HZ: cfg_prdata = hz_r;
      pclrm_pkg::REG_USABLE: cfg_prdata = {31'd0, usable_r};
      default: cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.period = period_r;
  assign cfg.hz = hz_r;
  assign cfg.usable = usable_r;

  pclrm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .stat(stat), .cmd(cmd)
  );

  pclrm_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .cfg(cfg), .in_item(in_tdata),
    .out_take(out_tvalid && out_tready), .stat(stat), .line(line),
    .out_valid(out_tvalid)
  );

  assign out_tdata = {5'd0, line.dropped, line.snap_us, line.read_us,
                      line.irq_read_us, line.fps, line.sensor};
  assign out_tlast = line.last;

endmodule
